// File: rtl/cau_pkg.sv
// Shared types, codes and sizes for the complex arithmetic unit.
package cau_pkg;

  localparam int CAU_FRAC_BITS = 16;
  // quotient bits developed by the divider chain (one per cell)
  localparam int CAU_QBITS     = 33;
  // front stages + divider cells + output register
  localparam int CAU_LATENCY   = 4 + CAU_QBITS + 1;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OVF = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic [1:0]         status;
  } cau_out_t;

  // payload handed from cell to cell
  typedef struct packed {
    logic [1:0]           cmd;
    logic                 dz;
    logic                 neg_re;
    logic                 neg_im;
    logic                 big_re;
    logic                 big_im;
    logic [63:0]          n_re;
    logic [63:0]          n_im;
    logic [63:0]          d;
    logic [63:0]          r_re;
    logic [63:0]          r_im;
    logic [CAU_QBITS-1:0] q_re;
    logic [CAU_QBITS-1:0] q_im;
  } cau_cell_t;

endpackage

// File: rtl/cau_front.sv
// Front end: products, combine, magnitude and divider setup (four stages).
module cau_front import cau_pkg::*; #(
  parameter int FRAC_BITS = CAU_FRAC_BITS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  cau_in_t   operands,
  output logic      vld_out,
  output cau_cell_t cell_out
);

  localparam int NW = 64 + FRAC_BITS;

  // stage 1
  logic              s1_vld;
  logic [1:0]        s1_cmd;
  logic [32:0]       sum_re, sum_im;
  logic signed [63:0] p_rr, p_ii, p_ri, p_ir, sq_r, sq_i;
  // stage 2
  logic              s2_vld;
  logic [1:0]        s2_cmd;
  logic [64:0]       v_re, v_im, v_re_next, v_im_next;
  logic [63:0]       s2_d;
  // stage 3
  logic              s3_vld;
  logic [1:0]        s3_cmd;
  logic              s3_dz, s3_neg_re, s3_neg_im;
  logic [63:0]       s3_n_re, s3_n_im, s3_d;
  // stage 4 setup
  logic [NW-1:0]     nx_re, nx_im;
  logic [63:0]       hi_re, hi_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      vld_out <= 1'b0;
    end else begin
      s1_vld <= accept;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      vld_out <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_cmd <= operands.cmd;
    if (operands.cmd == CMD_SUB) begin
      sum_re <= {operands.a_re[31], operands.a_re} - {operands.b_re[31], operands.b_re};
      sum_im <= {operands.a_im[31], operands.a_im} - {operands.b_im[31], operands.b_im};
    end else begin
      sum_re <= {operands.a_re[31], operands.a_re} + {operands.b_re[31], operands.b_re};
      sum_im <= {operands.a_im[31], operands.a_im} + {operands.b_im[31], operands.b_im};
    end
    p_rr <= $signed(operands.a_re) * $signed(operands.b_re);
    p_ii <= $signed(operands.a_im) * $signed(operands.b_im);
    p_ri <= $signed(operands.a_re) * $signed(operands.b_im);
    p_ir <= $signed(operands.a_im) * $signed(operands.b_re);
    sq_r <= $signed(operands.b_re) * $signed(operands.b_re);
    sq_i <= $signed(operands.b_im) * $signed(operands.b_im);
  end

  always_comb begin
    unique case (s1_cmd)
      CMD_MUL: begin
        v_re_next = {p_rr[63], p_rr} - {p_ii[63], p_ii};
        v_im_next = {p_ri[63], p_ri} + {p_ir[63], p_ir};
      end
      CMD_DIV: begin
        v_re_next = {p_rr[63], p_rr} + {p_ii[63], p_ii};
        v_im_next = {p_ir[63], p_ir} - {p_ri[63], p_ri};
      end
      default: begin
        v_re_next = {{32{sum_re[32]}}, sum_re};
        v_im_next = {{32{sum_im[32]}}, sum_im};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    s2_cmd <= s1_cmd;
    v_re   <= v_re_next;
    v_im   <= v_im_next;
    s2_d   <= sq_r[63:0] + sq_i[63:0];
  end

  // sign and magnitude; |v| <= 2^63 fits 64 bits
  always_ff @(posedge clk) begin
    s3_cmd    <= s2_cmd;
    s3_dz     <= (s2_d == 64'd0);
    s3_d      <= s2_d;
    s3_neg_re <= v_re[64];
    s3_neg_im <= v_im[64];
    s3_n_re   <= v_re[64] ? 64'(65'd0 - v_re) : v_re[63:0];
    s3_n_im   <= v_im[64] ? 64'(65'd0 - v_im) : v_im[63:0];
  end

  // quotient of n*2^F/d must stay below 2^QBITS, else it saturates anyway
  always_comb begin
    nx_re = NW'(s3_n_re) << FRAC_BITS;
    nx_im = NW'(s3_n_im) << FRAC_BITS;
    hi_re = 64'(nx_re[NW-1:CAU_QBITS]);
    hi_im = 64'(nx_im[NW-1:CAU_QBITS]);
  end

  always_ff @(posedge clk) begin
    cell_out.cmd    <= s3_cmd;
    cell_out.dz     <= s3_dz;
    cell_out.neg_re <= s3_neg_re;
    cell_out.neg_im <= s3_neg_im;
    cell_out.big_re <= (hi_re >= s3_d);
    cell_out.big_im <= (hi_im >= s3_d);
    cell_out.n_re   <= s3_n_re;
    cell_out.n_im   <= s3_n_im;
    cell_out.d      <= s3_d;
    cell_out.r_re   <= hi_re;
    cell_out.r_im   <= hi_im;
    cell_out.q_re   <= '0;
    cell_out.q_im   <= '0;
  end

endmodule

// File: rtl/cau_div_cell.sv
// One restoring-division cell: develops one quotient bit for both components.
module cau_div_cell import cau_pkg::*; #(
  parameter int FRAC_BITS = CAU_FRAC_BITS,
  parameter int BIT_POS   = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      vld_in,
  input  cau_cell_t cell_in,
  output logic      vld_out,
  output cau_cell_t cell_out
);

  localparam int NW = 64 + FRAC_BITS;

  logic [NW-1:0] nx_re, nx_im;
  logic [64:0]   t_re, t_im, dd;
  logic          ge_re, ge_im;
  cau_cell_t     cell_next;

  always_comb begin
    nx_re = NW'(cell_in.n_re) << FRAC_BITS;
    nx_im = NW'(cell_in.n_im) << FRAC_BITS;
    dd    = {1'b0, cell_in.d};
    t_re  = {cell_in.r_re, nx_re[BIT_POS]};
    t_im  = {cell_in.r_im, nx_im[BIT_POS]};
    ge_re = (t_re >= dd);
    ge_im = (t_im >= dd);
    cell_next      = cell_in;
    cell_next.r_re = ge_re ? 64'(t_re - dd) : t_re[63:0];
    cell_next.r_im = ge_im ? 64'(t_im - dd) : t_im[63:0];
    cell_next.q_re = {cell_in.q_re[CAU_QBITS-2:0], ge_re};
    cell_next.q_im = {cell_in.q_im[CAU_QBITS-2:0], ge_im};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    cell_out <= cell_next;
  end

endmodule

// File: rtl/cau_back.sv
// Back end: result selection, sign, saturation, status and output register.
module cau_back import cau_pkg::*; #(
  parameter int FRAC_BITS = CAU_FRAC_BITS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      vld_in,
  input  cau_cell_t cell_in,
  output logic      done,
  output cau_out_t  result
);

  logic [63:0] mag_re, mag_im;
  logic        big_re, big_im;
  logic [32:0] fin_re, fin_im;

  // {overflow, value}
  function automatic logic [32:0] finish(input logic neg, input logic big,
                                         input logic [63:0] mag);
    logic [32:0] r;
    if (neg) begin
      if (big || mag > 64'h8000_0000) r = {1'b1, 32'h8000_0000};
      else                            r = {1'b0, 32'(64'd0 - mag)};
    end else begin
      if (big || mag > 64'h7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else                            r = {1'b0, mag[31:0]};
    end
    return r;
  endfunction

  always_comb begin
    unique case (cell_in.cmd)
      CMD_DIV: begin
        mag_re = 64'(cell_in.q_re);
        mag_im = 64'(cell_in.q_im);
        big_re = cell_in.big_re;
        big_im = cell_in.big_im;
      end
      CMD_MUL: begin
        mag_re = cell_in.n_re >> FRAC_BITS;
        mag_im = cell_in.n_im >> FRAC_BITS;
        big_re = 1'b0;
        big_im = 1'b0;
      end
      default: begin
        mag_re = cell_in.n_re;
        mag_im = cell_in.n_im;
        big_re = 1'b0;
        big_im = 1'b0;
      end
    endcase
    fin_re = finish(cell_in.neg_re, big_re, mag_re);
    fin_im = finish(cell_in.neg_im, big_im, mag_im);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_in.cmd == CMD_DIV && cell_in.dz) begin
      result.res_re <= '0;
      result.res_im <= '0;
      result.status <= ST_DZ;
    end else begin
      result.res_re <= fin_re[31:0];
      result.res_im <= fin_im[31:0];
      result.status <= (fin_re[32] || fin_im[32]) ? ST_OVF : ST_OK;
    end
  end

endmodule

// File: rtl/complex_arith_unit.sv
// Top level of the pipelined complex add/subtract/multiply/divide unit.
//
// Usage:
//   Command channel: drive operands (cmd, a_re, a_im, b_re, b_im, signed
//   fixed point with FRAC_BITS fraction bits) and raise start. The item is
//   taken at any rising edge with start high and busy low.
//   Result channel: done pulses for one cycle with result (res_re, res_im,
//   status). status: ok, overflow (a component saturated), divide by zero
//   (both components zero). Results come out in command order.
// Timing:
//   Every command passes through the same path: 4 front stages
//   (products, combine, magnitude, divider setup), 33 divider cells (one
//   quotient bit each, both components in parallel), 1 output register.
//   Throughput is one item per cycle; add/sub/mul also ride the cell chain
//   so that order and latency stay fixed.
// Reset:
//   rst (synchronous) clears all valid flags; items in flight are dropped.
//   busy is high only during reset.
// Backpressure:
//   None; the receiver must take done/result in the cycle it is shown.
module complex_arith_unit import cau_pkg::*; #(
  parameter int FRAC_BITS = CAU_FRAC_BITS
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  cau_in_t  operands,
  output logic     done,
  output cau_out_t result
);

  logic                   accept;
  logic [CAU_QBITS:0]     chain_vld;
  cau_cell_t              chain [0:CAU_QBITS];

  assign busy   = rst;
  assign accept = start & ~busy;

  cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .operands (operands),
    .vld_out  (chain_vld[0]),
    .cell_out (chain[0])
  );

  // cell i produces quotient bit CAU_QBITS-1-i (msb first)
  for (genvar i = 0; i < CAU_QBITS; i++) begin : g_cell
    cau_div_cell #(
      .FRAC_BITS (FRAC_BITS),
      .BIT_POS   (CAU_QBITS - 1 - i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .vld_in   (chain_vld[i]),
      .cell_in  (chain[i]),
      .vld_out  (chain_vld[i+1]),
      .cell_out (chain[i+1])
    );
  end

  cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .vld_in   (chain_vld[CAU_QBITS]),
    .cell_in  (chain[CAU_QBITS]),
    .done     (done),
    .result   (result)
  );

endmodule

// File: rtl/cau_checker.sv
// Port-level checks for the complex arithmetic unit, bound to the top level.
module cau_checker import cau_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input logic     done,
  input cau_out_t result
);

  a_lat_fwd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##CAU_LATENCY done)
    else $error("item accepted without a result after fixed latency");

  a_lat_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, CAU_LATENCY))
    else $error("result without a matching item");

  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == ST_OK || result.status == ST_OVF ||
              result.status == ST_DZ))
    else $error("undefined status code");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_DZ) |-> (result.res_re == 32'sd0 &&
                                          result.res_im == 32'sd0))
    else $error("divide by zero result not zero");

endmodule

bind complex_arith_unit cau_checker u_cau_checker (.*);

// File: sim/complex_arith_unit_tb.sv
// Testbench for the complex arithmetic unit: directed and random items checked against a predictor.
`timescale 1ns / 100ps

module complex_arith_unit_tb;
  import cau_pkg::*;

  localparam int FB        = CAU_FRAC_BITS;
  localparam int CYC_LIMIT = 400000;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  cau_in_t  operands;
  logic     done;
  cau_out_t result;

  cau_out_t expected_q[$];
  bit       failed;
  int       cycles;
  int       send_idle_pct;  // percent of cycles the sender sits idle

  complex_arith_unit uut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .operands (operands),
    .done     (done),
    .result   (result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit: covers reset, every item's worst sender gap and the pipe latency.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Apply a sign to a magnitude and clamp to the 32-bit signed range.
  function automatic logic [31:0] clamp32(input bit neg, input logic [127:0] mag,
                                          inout bit ovf);
    if (neg) begin
      if (mag > 128'h8000_0000) begin
        ovf = 1'b1;
        return 32'h8000_0000;
      end
      return 32'(-mag);
    end
    if (mag > 128'h7FFF_FFFF) begin
      ovf = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return mag[31:0];
  endfunction

  // Exact complex arithmetic at 128 bits, truncated toward zero, then saturated.
  function automatic cau_out_t complex_result(input cau_in_t it);
    cau_out_t r;
    logic signed [127:0] ar, ai, br, bi, nre, nim, d;
    logic [127:0] mre, mim;
    bit ovf;
    ar = it.a_re; ai = it.a_im; br = it.b_re; bi = it.b_im;
    ovf = 1'b0;
    r = '0;
    case (it.cmd)
      CMD_ADD: begin
        nre = ar + br; nim = ai + bi;
      end
      CMD_SUB: begin
        nre = ar - br; nim = ai - bi;
      end
      CMD_MUL: begin
        nre = ar * br - ai * bi; nim = ar * bi + ai * br;
      end
      default: begin
        nre = ar * br + ai * bi; nim = ai * br - ar * bi;
        d = br * br + bi * bi;
      end
    endcase
    if (it.cmd == CMD_DIV && d == 0) begin
      r.status = ST_DZ;
      return r;
    end
    mre = (nre < 0) ? -nre : nre;
    mim = (nim < 0) ? -nim : nim;
    if (it.cmd == CMD_MUL) begin
      mre = mre >> FB; mim = mim >> FB;
    end else if (it.cmd == CMD_DIV) begin
      mre = (mre << FB) / d; mim = (mim << FB) / d;
    end
    r.res_re = clamp32(nre < 0, mre, ovf);
    r.res_im = clamp32(nim < 0, mim, ovf);
    r.status = ovf ? ST_OVF : ST_OK;
    return r;
  endfunction

  // Compare each strobed result with the oldest expectation.
  always @(posedge clk) begin
    cau_out_t e;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: re=%h im=%h st=%0d",
               result.res_re, result.res_im, result.status);
        failed = 1'b1;
      end else begin
        e = expected_q.pop_front();
        if (result.res_re !== e.res_re) begin
          $error("res_re expected %h actual %h", e.res_re, result.res_re);
          failed = 1'b1;
        end
        if (result.res_im !== e.res_im) begin
          $error("res_im expected %h actual %h", e.res_im, result.res_im);
          failed = 1'b1;
        end
        if (result.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, result.status);
          failed = 1'b1;
        end
      end
    end
  end

  // Send one item; start stays high across back-to-back items.
  task automatic send_item(input cau_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    operands <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.insert(expected_q.size(), complex_result(it));
  endtask

  task automatic release_start();
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_val();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(signed'($urandom_range(8)) - 4) << FB;  // small integers
      3: return 32'($urandom_range(65535));
      4: return '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic cau_in_t mk_item(input logic [1:0] c, input logic [31:0] a0,
                                      input logic [31:0] a1, input logic [31:0] b0,
                                      input logic [31:0] b1);
    cau_in_t it;
    it.cmd = c; it.a_re = a0; it.a_im = a1; it.b_re = b0; it.b_im = b1;
    return it;
  endfunction

  // Extremes, each operation, saturation both ways, divide by zero.
  task automatic test_directed();
    localparam logic [31:0] MX = 32'h7FFF_FFFF, MN = 32'h8000_0000, ONE = 32'h1_0000;
    send_item(mk_item(CMD_ADD, ONE, ONE, ONE, 32'hFFFF_0000));
    send_item(mk_item(CMD_ADD, MX, MN, MX, MN));        // saturate high and low
    send_item(mk_item(CMD_ADD, MX, MN, MN, MX));
    send_item(mk_item(CMD_SUB, MN, MX, MX, MN));
    send_item(mk_item(CMD_SUB, '0, '0, MN, MN));        // -min overflows
    send_item(mk_item(CMD_SUB, 32'h1234_5678, 32'hDEAD_BEEF, ONE, ONE));
    send_item(mk_item(CMD_MUL, ONE << 1, ONE * 3, ONE * 4, 32'hFFFB_0000));
    send_item(mk_item(CMD_MUL, MX, MX, MX, MX));
    send_item(mk_item(CMD_MUL, MN, MN, MN, MN));
    send_item(mk_item(CMD_MUL, MN, '0, MN, '0));
    send_item(mk_item(CMD_MUL, 32'hFFFF_FFFF, 32'h1, 32'h1, 32'hFFFF_FFFF));
    send_item(mk_item(CMD_DIV, ONE, ONE, '0, '0));      // divide by zero
    send_item(mk_item(CMD_DIV, MX, MN, '0, '0));
    send_item(mk_item(CMD_DIV, ONE * 5, ONE * 7, ONE, ONE * 2));
    send_item(mk_item(CMD_DIV, 32'hFFFF_FFFF, '0, ONE * 3, '0));  // truncate toward zero
    send_item(mk_item(CMD_DIV, MX, MX, 32'h1, '0));     // huge quotient
    send_item(mk_item(CMD_DIV, MN, MN, '0, 32'h1));
    send_item(mk_item(CMD_DIV, MN, MN, MN, MN));
    send_item(mk_item(CMD_DIV, MX, MN, MX, MX));
    send_item(mk_item(CMD_DIV, 32'h1, 32'h1, MN, MX));
    release_start();
  endtask

  task automatic test_random(input int n, input int idle_pct);
    send_idle_pct = idle_pct;
    repeat (n)
      send_item(mk_item(2'($urandom_range(3)), pick_val(), pick_val(), pick_val(),
                        pick_val()));
    release_start();
    send_idle_pct = 0;
  endtask

  // Hold the sender until the pipe has drained completely.
  task automatic drain_wait();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (CAU_LATENCY + 4) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1; start = 1'b0; operands = '0;
    failed = 1'b0; cycles = 0; send_idle_pct = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(120, 0);
    drain_wait();
    test_random(100, 87);
    test_random(80, 16);
    test_random(100, 0);
    drain_wait();
    if (!failed && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (expected_q.size() != 0)
        $error("%0d results never arrived", expected_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
